// ===== rtl/nwl_pkg.sv =====
`default_nettype none
package nwl_pkg;

   // port and accumulator widths
   localparam int COORD_W        = 16;
   localparam int COORD_MAX_BITS = 24;
   localparam int COORD_BITS_DEF = 16;
   localparam int ACC_W          = 48;
   localparam int OUT_W          = 16;

   // norm unit: squares built from 16-bit digits
   localparam int DIGIT_W  = 16;
   localparam int N_DIGITS = ACC_W / DIGIT_W;
   localparam int SQ_W     = 2 * ACC_W;
   localparam int QUO_W    = 29;
   localparam int ROOT_W   = 15;

   // finished Newell sums of one polygon
   typedef struct packed {
      logic signed [ACC_W-1:0] a;
      logic signed [ACC_W-1:0] b;
      logic signed [ACC_W-1:0] c;
   } nwl_sums_type;

endpackage
`default_nettype wire

// ===== rtl/nwl_front.sv =====
`default_nettype none
module nwl_front #(
   parameter int COORD_BITS = nwl_pkg::COORD_BITS_DEF
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_valid,
   output logic                                   req_stall,
   input  wire logic signed [nwl_pkg::COORD_W-1:0] req_coord_x,
   input  wire logic signed [nwl_pkg::COORD_W-1:0] req_coord_y,
   input  wire logic signed [nwl_pkg::COORD_W-1:0] req_coord_z,
   input  wire logic                              req_last_vertex,
   output logic                                   push,
   output nwl_pkg::nwl_sums_type                  push_sums,
   input  wire logic                              q_full
);
   localparam int CB  = COORD_BITS;
   localparam int AW  = nwl_pkg::ACC_W;
   localparam int TW  = 2 * CB + 2;
   localparam int SW  = ((TW > AW) ? TW : AW) + 1;
   localparam int PAD = nwl_pkg::COORD_MAX_BITS - nwl_pkg::COORD_W;

   logic in_face_ff, in_face_in;
   logic close_ff, close_in;
   logic signed [CB-1:0] fx_ff, fy_ff, fz_ff, fx_in, fy_in, fz_in;
   logic signed [CB-1:0] px_ff, py_ff, pz_ff, px_in, py_in, pz_in;
   logic signed [AW-1:0] sa_ff, sb_ff, sc_ff, sa_in, sb_in, sc_in;

   logic [nwl_pkg::COORD_MAX_BITS-1:0] ext_x, ext_y, ext_z;
   logic signed [CB-1:0] cx, cy, cz, qx, qy, qz;
   logic signed [CB:0]   dx, dy, dz, ax, ay, az;
   logic signed [TW-1:0] ta, tb, tc;
   logic signed [SW-1:0] ra, rb, rc;
   logic signed [AW-1:0] na, nb, nc;
   logic accept;

   // clamp a widened sum back into the accumulator range
   function automatic logic signed [AW-1:0] clamp(input logic signed [SW-1:0] v);
      logic [SW-AW:0] top;
      top = v[SW-1:AW-1];
      if (top == '0 || top == '1) begin
         clamp = v[AW-1:0];
      end else if (v[SW-1]) begin
         clamp = {1'b1, {(AW-1){1'b0}}};
      end else begin
         clamp = {1'b0, {(AW-1){1'b1}}};
      end
   endfunction

   // low COORD_BITS of each coordinate, two's complement
   assign ext_x = {{PAD{1'b0}}, req_coord_x};
   assign ext_y = {{PAD{1'b0}}, req_coord_y};
   assign ext_z = {{PAD{1'b0}}, req_coord_z};
   assign cx = $signed(ext_x[CB-1:0]);
   assign cy = $signed(ext_y[CB-1:0]);
   assign cz = $signed(ext_z[CB-1:0]);

   assign req_stall = close_ff;
   assign accept    = req_valid && !req_stall;

   // pair term: p is the previous vertex, q the new or the first one
   assign qx = close_ff ? fx_ff : cx;
   assign qy = close_ff ? fy_ff : cy;
   assign qz = close_ff ? fz_ff : cz;
   assign dx = {px_ff[CB-1], px_ff} - {qx[CB-1], qx};
   assign dy = {py_ff[CB-1], py_ff} - {qy[CB-1], qy};
   assign dz = {pz_ff[CB-1], pz_ff} - {qz[CB-1], qz};
   assign ax = {px_ff[CB-1], px_ff} + {qx[CB-1], qx};
   assign ay = {py_ff[CB-1], py_ff} + {qy[CB-1], qy};
   assign az = {pz_ff[CB-1], pz_ff} + {qz[CB-1], qz};
   assign ta = dy * az;
   assign tb = dz * ax;
   assign tc = dx * ay;
   assign ra = SW'(sa_ff) + SW'(ta);
   assign rb = SW'(sb_ff) + SW'(tb);
   assign rc = SW'(sc_ff) + SW'(tc);
   assign na = clamp(ra);
   assign nb = clamp(rb);
   assign nc = clamp(rc);

   assign push        = close_ff && !q_full;
   assign push_sums.a = na;
   assign push_sums.b = nb;
   assign push_sums.c = nc;

   // vertex tracking and accumulation
   always_comb begin
      in_face_in = in_face_ff;
      close_in   = close_ff;
      fx_in = fx_ff; fy_in = fy_ff; fz_in = fz_ff;
      px_in = px_ff; py_in = py_ff; pz_in = pz_ff;
      sa_in = sa_ff; sb_in = sb_ff; sc_in = sc_ff;
      if (push) begin
         in_face_in = 1'b0;
         close_in   = 1'b0;
         fx_in = '0; fy_in = '0; fz_in = '0;
         px_in = '0; py_in = '0; pz_in = '0;
         sa_in = '0; sb_in = '0; sc_in = '0;
      end else if (accept) begin
         if (!in_face_ff) begin
            fx_in = cx; fy_in = cy; fz_in = cz;
            sa_in = '0; sb_in = '0; sc_in = '0;
            in_face_in = 1'b1;
         end else begin
            sa_in = na; sb_in = nb; sc_in = nc;
         end
         px_in = cx; py_in = cy; pz_in = cz;
         close_in = req_last_vertex;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_face_ff <= 1'b0;
         close_ff   <= 1'b0;
         fx_ff <= '0; fy_ff <= '0; fz_ff <= '0;
         px_ff <= '0; py_ff <= '0; pz_ff <= '0;
         sa_ff <= '0; sb_ff <= '0; sc_ff <= '0;
      end else begin
         in_face_ff <= in_face_in;
         close_ff   <= close_in;
         fx_ff <= fx_in; fy_ff <= fy_in; fz_ff <= fz_in;
         px_ff <= px_in; py_ff <= py_in; pz_ff <= pz_in;
         sa_ff <= sa_in; sb_ff <= sb_in; sc_ff <= sc_in;
      end
   end
endmodule
`default_nettype wire

// ===== rtl/nwl_queue.sv =====
`default_nettype none
module nwl_queue (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  push,
   input  wire nwl_pkg::nwl_sums_type push_sums,
   output logic                       q_full,
   output logic                       q_valid,
   output nwl_pkg::nwl_sums_type      q_sums,
   input  wire logic                  pop
);
   nwl_pkg::nwl_sums_type slot_ff [2];
   logic       wr_ff, wr_in, rd_ff, rd_in;
   logic [1:0] cnt_ff, cnt_in;

   assign q_full  = (cnt_ff == 2'd2);
   assign q_valid = (cnt_ff != 2'd0);
   assign q_sums  = slot_ff[rd_ff];

   // pointers and fill count
   always_comb begin
      wr_in  = wr_ff;
      rd_in  = rd_ff;
      cnt_in = cnt_ff;
      if (push) begin
         wr_in = !wr_ff;
      end
      if (pop) begin
         rd_in = !rd_ff;
      end
      if (push && !pop) begin
         cnt_in = cnt_ff + 2'd1;
      end else if (pop && !push) begin
         cnt_in = cnt_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= 1'b0;
         rd_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ff] <= push_sums;
      end
   end
endmodule
`default_nettype wire

// ===== rtl/nwl_back.sv =====
`default_nettype none
module nwl_back (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  q_valid,
   input  wire nwl_pkg::nwl_sums_type q_sums,
   output logic                       pop,
   output logic                       rsp_valid,
   input  wire logic                  rsp_stall,
   output logic signed [nwl_pkg::OUT_W-1:0] rsp_normal_x,
   output logic signed [nwl_pkg::OUT_W-1:0] rsp_normal_y,
   output logic signed [nwl_pkg::OUT_W-1:0] rsp_normal_z,
   output logic                       rsp_degenerate
);
   localparam int AW = nwl_pkg::ACC_W;
   localparam int DW = nwl_pkg::DIGIT_W;
   localparam int QW = nwl_pkg::SQ_W;
   localparam int UW = nwl_pkg::QUO_W;
   localparam int RW = nwl_pkg::ROOT_W;
   localparam int OW = nwl_pkg::OUT_W;

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_SQR   = 3'd1;
   localparam logic [2:0] ST_DINIT = 3'd2;
   localparam logic [2:0] ST_DIV   = 3'd3;
   localparam logic [2:0] ST_ROOT  = 3'd4;
   localparam logic [2:0] ST_OUT   = 3'd5;

   logic [2:0] state_ff, state_in;
   logic [1:0] k_ff, k_in, d_ff, d_in;
   logic [4:0] cnt_ff, cnt_in;
   logic [AW-1:0] mag_ff [3];
   logic [AW-1:0] mag_in [3];
   logic [2:0]    neg_ff, neg_in;
   logic [QW-1:0] sq_ff [3];
   logic [QW-1:0] sq_in [3];
   logic [QW-1:0] s_ff, s_in;
   logic [QW:0]   rem_ff, rem_in;
   logic [UW-1:0] quo_ff, quo_in;
   logic [RW-1:0] root_ff, root_in;
   logic signed [OW-1:0] res_ff [3];
   logic signed [OW-1:0] res_in [3];
   logic degen_ff, degen_in;

   logic [DW-1:0]    digit;
   logic [AW+DW-1:0] pp;
   logic [QW-1:0]    pp_sh;
   logic [QW:0]      sh;
   logic             ge;
   logic [RW-1:0]    trial;
   logic [2*RW-1:0]  tsq;
   logic [RW-1:0]    m_next;

   // one 48x16 digit product per cycle
   assign digit = mag_ff[k_ff][d_ff*DW +: DW];
   assign pp    = mag_ff[k_ff] * digit;
   assign pp_sh = QW'(pp) << (d_ff * DW);

   // restoring divide step: floor(2^28 * comp^2 / S)
   assign sh = {rem_ff[QW-1:0], (cnt_ff == 5'(UW-1)) ? sq_ff[k_ff][0] : 1'b0};
   assign ge = (sh >= {1'b0, s_ff});

   // square root step, one result bit a cycle
   assign trial  = root_ff | (RW'(1) << cnt_ff[3:0]);
   assign tsq    = trial * trial;
   assign m_next = ({1'b0, tsq} <= (2*RW+1)'(quo_ff)) ? trial : root_ff;

   assign pop            = (state_ff == ST_IDLE) && q_valid;
   assign rsp_valid      = (state_ff == ST_OUT);
   assign rsp_normal_x   = res_ff[0];
   assign rsp_normal_y   = res_ff[1];
   assign rsp_normal_z   = res_ff[2];
   assign rsp_degenerate = degen_ff;

   always_comb begin
      state_in = state_ff;
      k_in     = k_ff;
      d_in     = d_ff;
      cnt_in   = cnt_ff;
      mag_in   = mag_ff;
      neg_in   = neg_ff;
      sq_in    = sq_ff;
      s_in     = s_ff;
      rem_in   = rem_ff;
      quo_in   = quo_ff;
      root_in  = root_ff;
      res_in   = res_ff;
      degen_in = degen_ff;
      case (state_ff)
         ST_IDLE: begin
            if (q_valid) begin
               neg_in    = {q_sums.c[AW-1], q_sums.b[AW-1], q_sums.a[AW-1]};
               mag_in[0] = q_sums.a[AW-1] ? -q_sums.a : q_sums.a;
               mag_in[1] = q_sums.b[AW-1] ? -q_sums.b : q_sums.b;
               mag_in[2] = q_sums.c[AW-1] ? -q_sums.c : q_sums.c;
               sq_in[0]  = '0;
               sq_in[1]  = '0;
               sq_in[2]  = '0;
               s_in      = '0;
               k_in      = 2'd0;
               d_in      = 2'd0;
               if (q_sums.a == '0 && q_sums.b == '0 && q_sums.c == '0) begin
                  res_in[0] = '0;
                  res_in[1] = '0;
                  res_in[2] = '0;
                  degen_in  = 1'b1;
                  state_in  = ST_OUT;
               end else begin
                  degen_in = 1'b0;
                  state_in = ST_SQR;
               end
            end
         end
         ST_SQR: begin
            sq_in[k_ff] = sq_ff[k_ff] + pp_sh;
            s_in        = s_ff + pp_sh;
            if (d_ff == 2'(nwl_pkg::N_DIGITS - 1)) begin
               d_in = 2'd0;
               if (k_ff == 2'd2) begin
                  k_in     = 2'd0;
                  state_in = ST_DINIT;
               end else begin
                  k_in = k_ff + 2'd1;
               end
            end else begin
               d_in = d_ff + 2'd1;
            end
         end
         ST_DINIT: begin
            rem_in   = {2'b00, sq_ff[k_ff][QW-1:1]};
            quo_in   = '0;
            cnt_in   = 5'(UW - 1);
            state_in = ST_DIV;
         end
         ST_DIV: begin
            rem_in = ge ? (sh - {1'b0, s_ff}) : sh;
            quo_in = {quo_ff[UW-2:0], ge};
            if (cnt_ff == 5'd0) begin
               cnt_in   = 5'(RW - 1);
               root_in  = '0;
               state_in = ST_ROOT;
            end else begin
               cnt_in = cnt_ff - 5'd1;
            end
         end
         ST_ROOT: begin
            root_in = m_next;
            if (cnt_ff == 5'd0) begin
               res_in[k_ff] = neg_ff[k_ff] ? -OW'(m_next) : OW'(m_next);
               if (k_ff == 2'd2) begin
                  state_in = ST_OUT;
               end else begin
                  k_in     = k_ff + 2'd1;
                  state_in = ST_DINIT;
               end
            end else begin
               cnt_in = cnt_ff - 5'd1;
            end
         end
         ST_OUT: begin
            if (!rsp_stall) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         k_ff     <= 2'd0;
         d_ff     <= 2'd0;
         cnt_ff   <= 5'd0;
      end else begin
         state_ff <= state_in;
         k_ff     <= k_in;
         d_ff     <= d_in;
         cnt_ff   <= cnt_in;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      mag_ff   <= mag_in;
      neg_ff   <= neg_in;
      sq_ff    <= sq_in;
      s_ff     <= s_in;
      rem_ff   <= rem_in;
      quo_ff   <= quo_in;
      root_ff  <= root_in;
      res_ff   <= res_in;
      degen_ff <= degen_in;
   end
endmodule
`default_nettype wire

// ===== rtl/newell_polygon_normal.sv =====
// Flow: each vertex word is taken while req_stall is low; after the last one, input
//   stalls until the polygon's sums enter the queue, then the norm unit makes the normal word.
// Norm unit: 9 digit products, then per component a 29-step divide and a 15-step
//   square root; pops sums from a two-entry queue only after its last result is taken.
// Reset: synchronous, active high; clears all sums, vertices and queue.
`default_nettype none
module newell_polygon_normal #(
   parameter int COORD_BITS = nwl_pkg::COORD_BITS_DEF
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_valid,
   output logic                                   req_stall,
   input  wire logic signed [nwl_pkg::COORD_W-1:0] req_coord_x,
   input  wire logic signed [nwl_pkg::COORD_W-1:0] req_coord_y,
   input  wire logic signed [nwl_pkg::COORD_W-1:0] req_coord_z,
   input  wire logic                              req_last_vertex,
   output logic                                   rsp_valid,
   input  wire logic                              rsp_stall,
   output logic signed [nwl_pkg::OUT_W-1:0]       rsp_normal_x,
   output logic signed [nwl_pkg::OUT_W-1:0]       rsp_normal_y,
   output logic signed [nwl_pkg::OUT_W-1:0]       rsp_normal_z,
   output logic                                   rsp_degenerate
);
   logic push, q_full, q_valid, pop;
   nwl_pkg::nwl_sums_type push_sums, q_sums;

   nwl_front #(.COORD_BITS(COORD_BITS)) u_front (
      .clock, .reset, .req_valid, .req_stall,
      .req_coord_x, .req_coord_y, .req_coord_z, .req_last_vertex,
      .push, .push_sums, .q_full
   );

   nwl_queue u_queue (
      .clock, .reset, .push, .push_sums, .q_full, .q_valid, .q_sums, .pop
   );

   nwl_back u_back (
      .clock, .reset, .q_valid, .q_sums, .pop,
      .rsp_valid, .rsp_stall, .rsp_normal_x, .rsp_normal_y, .rsp_normal_z,
      .rsp_degenerate
   );
endmodule
`default_nettype wire

// ===== rtl/nwl_checker.sv =====
`default_nettype none
module nwl_checker (
   input wire logic                              clock,
   input wire logic                              reset,
   input wire logic                              req_valid,
   input wire logic                              req_stall,
   input wire logic                              req_last_vertex,
   input wire logic                              rsp_valid,
   input wire logic                              rsp_stall,
   input wire logic signed [nwl_pkg::OUT_W-1:0]  rsp_normal_x,
   input wire logic signed [nwl_pkg::OUT_W-1:0]  rsp_normal_y,
   input wire logic signed [nwl_pkg::OUT_W-1:0]  rsp_normal_z,
   input wire logic                              rsp_degenerate
);
   // a stalled result word holds
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_normal_x)
         && $stable(rsp_normal_y) && $stable(rsp_normal_z) && $stable(rsp_degenerate))
      else $error("result word changed while stalled");

   // degenerate face gives the zero vector
   a_degen: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_degenerate |->
         rsp_normal_x == '0 && rsp_normal_y == '0 && rsp_normal_z == '0)
      else $error("degenerate result with nonzero component");

   // unit components stay within one
   a_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_normal_x <= 16384 && rsp_normal_x >= -16384
         && rsp_normal_y <= 16384 && rsp_normal_y >= -16384
         && rsp_normal_z <= 16384 && rsp_normal_z >= -16384)
      else $error("normal component out of range");

   // input stalls only to close a polygon
   a_stall: assert property (@(posedge clock) disable iff (reset)
      $rose(req_stall) |-> $past(req_valid && req_last_vertex))
      else $error("input stalled without a last vertex");

   // nothing offered right after reset
   a_reset: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result offered after reset");
endmodule

bind newell_polygon_normal nwl_checker u_nwl_checker (.*);
`default_nettype wire

// ===== test/testbench.sv =====
`default_nettype none
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int     COORD_W = nwl_pkg::COORD_W;
   localparam int     OUT_W   = nwl_pkg::OUT_W;
   localparam longint SUM_MAX = 64'sd140737488355327;
   localparam longint SUM_MIN = -SUM_MAX - 1;
   localparam int     UNIT    = 16384;

   typedef struct {
      logic signed [OUT_W-1:0] nx;
      logic signed [OUT_W-1:0] ny;
      logic signed [OUT_W-1:0] nz;
      logic                    degen;
   } normal_word_type;

   logic clock;
   logic reset;
   logic req_valid;
   logic req_stall;
   logic signed [COORD_W-1:0] req_coord_x, req_coord_y, req_coord_z;
   logic req_last_vertex;
   logic rsp_valid;
   logic rsp_stall;
   logic signed [OUT_W-1:0] rsp_normal_x, rsp_normal_y, rsp_normal_z;
   logic rsp_degenerate;

   // predictor state
   bit     poly_open;
   longint first_x, first_y, first_z;
   longint prev_x, prev_y, prev_z;
   longint sum_a, sum_b, sum_c;

   normal_word_type expected_normals[$];
   int  mismatches;
   bit  no_gaps;

   newell_polygon_normal dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall),
      .req_coord_x(req_coord_x), .req_coord_y(req_coord_y),
      .req_coord_z(req_coord_z), .req_last_vertex(req_last_vertex),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_normal_x(rsp_normal_x), .rsp_normal_y(rsp_normal_y),
      .rsp_normal_z(rsp_normal_z), .rsp_degenerate(rsp_degenerate)
   );

   always begin
      clock = 1'b1;
      #6;
      clock = 1'b0;
      #6;
   end

   // saturating accumulate
   function automatic longint clamp_add(longint acc, longint t);
      longint r;
      r = acc + t;
      if (r > SUM_MAX) return SUM_MAX;
      if (r < SUM_MIN) return SUM_MIN;
      return r;
   endfunction

   task automatic add_edge(longint px, longint py, longint pz,
                           longint qx, longint qy, longint qz);
      sum_a = clamp_add(sum_a, (py - qy) * (pz + qz));
      sum_b = clamp_add(sum_b, (pz - qz) * (px + qx));
      sum_c = clamp_add(sum_c, (px - qx) * (py + qy));
   endtask

   // largest m with m*m*len2 <= 2^28*comp^2, signed like comp
   function automatic logic [OUT_W-1:0] unit_component(longint comp, logic [127:0] len2);
      logic [127:0] mag;
      logic [127:0] lim;
      logic [127:0] m;
      int lo, hi, mid;
      mag = (comp < 0) ? -comp : comp;
      lim = (mag * mag) << 28;
      lo = 0;
      hi = UNIT;
      while (lo < hi) begin
         mid = (lo + hi + 1) / 2;
         m = mid;
         if (len2 * m * m <= lim) lo = mid;
         else hi = mid - 1;
      end
      return (comp < 0) ? OUT_W'(-lo) : OUT_W'(lo);
   endfunction

   task automatic predict_vertex(logic signed [COORD_W-1:0] x, y, z, logic last);
      longint cx, cy, cz;
      logic [127:0] ma, mb, mc, len2;
      normal_word_type w;
      cx = x;
      cy = y;
      cz = z;
      if (!poly_open) begin
         first_x = cx; first_y = cy; first_z = cz;
         sum_a = 0; sum_b = 0; sum_c = 0;
         poly_open = 1;
      end else begin
         add_edge(prev_x, prev_y, prev_z, cx, cy, cz);
      end
      prev_x = cx; prev_y = cy; prev_z = cz;
      if (!last) return;
      add_edge(cx, cy, cz, first_x, first_y, first_z);
      if (sum_a == 0 && sum_b == 0 && sum_c == 0) begin
         w = '{0, 0, 0, 1'b1};
      end else begin
         ma = (sum_a < 0) ? -sum_a : sum_a;
         mb = (sum_b < 0) ? -sum_b : sum_b;
         mc = (sum_c < 0) ? -sum_c : sum_c;
         len2 = ma * ma + mb * mb + mc * mc;
         w.nx = unit_component(sum_a, len2);
         w.ny = unit_component(sum_b, len2);
         w.nz = unit_component(sum_c, len2);
         w.degen = 1'b0;
      end
      expected_normals.push_back(w);
      poly_open = 0;
      first_x = 0; first_y = 0; first_z = 0;
      prev_x = 0; prev_y = 0; prev_z = 0;
      sum_a = 0; sum_b = 0; sum_c = 0;
   endtask

   // send one vertex word, predict on acceptance; valid stays up until the next call
   task automatic send_vertex(logic signed [COORD_W-1:0] x, y, z, logic last);
      int gap;
      bit taken;
      gap = no_gaps ? 0 : $urandom_range(0, 19);
      @(negedge clock);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid       <= 1'b1;
      req_coord_x     <= x;
      req_coord_y     <= y;
      req_coord_z     <= z;
      req_last_vertex <= last;
      do begin
         @(posedge clock);
         taken = req_valid && !req_stall;
      end while (!taken);
      predict_vertex(x, y, z, last);
   endtask

   function automatic logic signed [COORD_W-1:0] rand_coord();
      case ($urandom_range(0, 3))
         0: return $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
         1: return COORD_W'($urandom_range(0, 511)) - 16'sd256;
         default: return COORD_W'($urandom);
      endcase
   endfunction

   task automatic send_polygon(int n);
      for (int i = 0; i < n; i++)
         send_vertex(rand_coord(), rand_coord(), rand_coord(), i == n - 1);
   endtask

   // degenerate shapes: single vertex, two vertices, collinear
   task automatic test_degenerate();
      send_vertex(16'sh7FFF, 16'sh8000, 16'sh1234, 1'b1);
      send_vertex(16'sh8000, 16'sh7FFF, 16'sh0000, 1'b0);
      send_vertex(16'sh7FFF, 16'sh8000, 16'sh7FFF, 1'b1);
      send_vertex(16'sh0100, 16'sh0100, 16'sh0100, 1'b0);
      send_vertex(16'sh0200, 16'sh0200, 16'sh0200, 1'b0);
      send_vertex(16'sh0300, 16'sh0300, 16'sh0300, 1'b1);
   endtask

   // axis triangles, an extreme quad and a mixed-value triangle
   task automatic test_extremes();
      send_vertex(16'sh0000, 16'sh0000, 16'sh0000, 1'b0);
      send_vertex(16'sh0100, 16'sh0000, 16'sh0000, 1'b0);
      send_vertex(16'sh0000, 16'sh0100, 16'sh0000, 1'b1);
      send_vertex(16'sh0000, 16'sh0000, 16'sh0000, 1'b0);
      send_vertex(16'sh0000, 16'sh0000, 16'sh0100, 1'b0);
      send_vertex(16'sh0000, 16'sh0100, 16'sh0000, 1'b1);
      send_vertex(16'sh8000, 16'sh8000, 16'sh8000, 1'b0);
      send_vertex(16'sh7FFF, 16'sh8000, 16'sh7FFF, 1'b0);
      send_vertex(16'sh7FFF, 16'sh7FFF, 16'sh8000, 1'b0);
      send_vertex(16'sh8000, 16'sh7FFF, 16'sh7FFF, 1'b1);
      send_vertex(16'shFFFF, 16'sh0001, 16'shAAAA, 1'b0);
      send_vertex(16'sh5555, 16'shFFFF, 16'sh0001, 1'b0);
      send_vertex(16'sh0001, 16'sh5555, 16'shFFFF, 1'b1);
   endtask

   // long polygon with same-sign terms builds large sums, back to back
   task automatic test_saturation();
      no_gaps = 1;
      for (int i = 0; i < 100; i++) begin
         send_vertex(16'sh8000, 16'sh8000, 16'sh7FFF, 1'b0);
         send_vertex(16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 1'b0);
         send_vertex(16'sh7FFF, 16'sh7FFF, 16'sh8000, i == 99);
      end
      no_gaps = 0;
   endtask

   task automatic test_random();
      int sent;
      int n;
      sent = 0;
      while (sent < 780) begin
         case ($urandom_range(0, 19))
            0:       n = $urandom_range(1, 2);
            1:       n = $urandom_range(20, 100);
            default: n = $urandom_range(3, 8);
         endcase
         no_gaps = ($urandom_range(0, 9) == 0);
         send_polygon(n);
         sent += n;
      end
      no_gaps = 0;
   endtask

   // result stall pattern
   initial begin
      int n;
      rsp_stall = 1'b0;
      forever begin
         n = no_gaps ? 0 : $urandom_range(0, 19);
         repeat (n) begin
            @(negedge clock);
            rsp_stall <= 1'b1;
         end
         @(negedge clock);
         rsp_stall <= 1'b0;
         do @(posedge clock); while (!rsp_valid);
      end
   end

   // result checking
   always @(posedge clock) begin
      normal_word_type w;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_normals.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected normal word %0d %0d %0d deg=%0b",
                        rsp_normal_x, rsp_normal_y, rsp_normal_z, rsp_degenerate);
         end else begin
            w = expected_normals.pop_front();
            if (rsp_normal_x !== w.nx || rsp_normal_y !== w.ny ||
                rsp_normal_z !== w.nz || rsp_degenerate !== w.degen) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("normal mismatch: exp %0d %0d %0d deg=%0b got %0d %0d %0d deg=%0b",
                           w.nx, w.ny, w.nz, w.degen, rsp_normal_x, rsp_normal_y,
                           rsp_normal_z, rsp_degenerate);
            end
         end
      end
   end

   initial begin
      #(12ns * 4000000);
      $display("RESULT: ERROR");
      $finish;
   end

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_coord_x = '0;
      req_coord_y = '0;
      req_coord_z = '0;
      req_last_vertex = 1'b0;
      mismatches = 0;
      no_gaps = 0;
      poly_open = 0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_degenerate();
      test_extremes();
      test_random();
      test_saturation();
      @(negedge clock);
      req_valid <= 1'b0;
      while (expected_normals.size() != 0) @(posedge clock);
      repeat (300) @(posedge clock);
      if (mismatches == 0 && expected_normals.size() == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

endmodule
`default_nettype wire

// ===== files.f =====
rtl/nwl_pkg.sv
rtl/nwl_front.sv
rtl/nwl_queue.sv
rtl/nwl_back.sv
rtl/newell_polygon_normal.sv
rtl/nwl_checker.sv
test/testbench.sv
